>>> src/hng_pkg.sv
package hng_pkg;

  // Configuration defaults and fixed field widths
  localparam int MAX_SIDE_DEF = 256;
  localparam int SIDE_CFG_W   = 9;
  localparam int GAIN_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 9'd256;
  localparam logic [GAIN_W-1:0]     GAIN_RESET = 16'd2560;

  // Arithmetic widths: squared length fits 52 bits, length 26 bits
  localparam int Q_W   = 52;
  localparam int LEN_W = 26;
  localparam int MAG_W = 26;
  localparam int PRD_W = 27;
  localparam int FRAC  = 14;
  localparam int DIV_W = MAG_W + FRAC + 1;
  localparam int QUO_W = 15;
  localparam int NRM_W = 16;

  // Fixed y term: 2 * 255 * 256, and its square
  localparam logic [MAG_W-1:0] SCALE_Y    = 26'd130560;
  localparam logic [Q_W-1:0]   SCALE_Y_SQ = 52'd17045913600;
  localparam logic [Q_W-1:0]   ROOT_BIT0  = 52'h4_0000_0000_0000;

  typedef enum logic [0:0] {
    CFG_SIDE_LENGTH = 1'b0,
    CFG_HEIGHT_GAIN = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_MUL, S_SQR, S_SUM, S_ROOT, S_DIVI, S_DIV, S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic rd1;       // row buffer read phase 1 (phase 0 otherwise)
    logic cap0;      // capture phase 0 read data
    logic cap1;      // capture phase 1 read data
    logic wr;        // shift column into row buffers
    logic mul;
    logic sqr;
    logic sum;
    logic root_step;
    logic div_init;
    logic div_step;
    logic load_out;
    logic flush;     // current transaction is a flush
    logic l_zero;    // left neighbor outside the map
    logic r_zero;    // right neighbor outside the map
    logic d_zero;    // lower neighbor outside the map
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic root_last;
    logic div_last;
    logic comp_last;
  } dp_sts_t;

  // Map raw sample s to 2s - 255
  function automatic logic signed [8:0] centered(input logic [7:0] s);
    logic signed [9:0] t;
    t = $signed({1'b0, s, 1'b0}) - 10'sd255;
    return t[8:0];
  endfunction

endpackage

>>> src/hng_ram.sv
module hng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/hng_dp.sv
module hng_dp import hng_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int AW = $clog2(MAX_SIDE)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic [AW-1:0]            col,
  input  logic [7:0]               sample,
  input  logic [GAIN_W-1:0]        gain,
  output logic signed [NRM_W-1:0]  out_normal_x,
  output logic signed [NRM_W-1:0]  out_normal_y,
  output logic signed [NRM_W-1:0]  out_normal_z
);

  logic [AW-1:0] col_m1, col_p1;
  logic [AW-1:0] old_raddr, new_raddr;
  logic [7:0]    old_q, new_q;

  logic signed [8:0] a_l_r, a_r_r, a_d_r, a_u_r;
  logic signed [9:0] dx, dz;
  logic signed [16:0] gain_s;
  logic signed [PRD_W-1:0] x_r, z_r;
  logic [PRD_W-1:0] neg_x, neg_z;
  logic [MAG_W-1:0] mag_x, mag_z, mag_sel;
  logic [Q_W-1:0] xx_r, zz_r;

  logic [Q_W-1:0] rem_r, root_r, bit_r, root_try;
  logic [LEN_W-1:0] len;

  comp_sel_t sel_r;
  logic [DIV_W-1:0] drem_r, dvs_r;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [3:0] dcnt_r;
  logic q_bit, sign_sel;
  logic [NRM_W-1:0] comp_mag, comp_val;
  logic signed [NRM_W-1:0] nx_r, ny_r, nz_r;
  logic signed [NRM_W-1:0] ox_r, oy_r, oz_r;

  // Row buffers outside flush: phase 0 reads left/right, phase 1 the column
  assign col_m1 = col - 1'b1;
  assign col_p1 = col + 1'b1;
  assign old_raddr = cmd.rd1 ? col : (cmd.flush ? col : col_m1);
  assign new_raddr = cmd.rd1 ? (cmd.flush ? col_m1 : col) : col_p1;

  hng_ram #(.WIDTH(8), .DEPTH(MAX_SIDE)) u_older (
    .clk(clk), .wr_en(cmd.wr), .wr_addr(col), .wr_data(new_q),
    .rd_addr(old_raddr), .rd_data(old_q)
  );

  hng_ram #(.WIDTH(8), .DEPTH(MAX_SIDE)) u_newer (
    .clk(clk), .wr_en(cmd.wr), .wr_addr(col), .wr_data(sample),
    .rd_addr(new_raddr), .rd_data(new_q)
  );

  // Capture neighbor heights, zero outside the map
  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      a_r_r <= cmd.r_zero ? 9'sd0 : centered(new_q);
      if (cmd.flush) begin
        a_d_r <= centered(old_q);
      end else begin
        a_l_r <= cmd.l_zero ? 9'sd0 : centered(old_q);
      end
    end
    if (cmd.cap1) begin
      a_u_r <= cmd.flush ? 9'sd0 : centered(sample);
      if (cmd.flush) begin
        a_l_r <= cmd.l_zero ? 9'sd0 : centered(new_q);
      end else begin
        a_d_r <= cmd.d_zero ? 9'sd0 : centered(old_q);
      end
    end
  end

  // Gradient scaling, squaring and sum
  assign dx = 10'(a_l_r) - 10'(a_r_r);
  assign dz = 10'(a_d_r) - 10'(a_u_r);
  assign gain_s = $signed({1'b0, gain});
  assign neg_x = -x_r;
  assign neg_z = -z_r;
  assign mag_x = x_r[PRD_W-1] ? neg_x[MAG_W-1:0] : x_r[MAG_W-1:0];
  assign mag_z = z_r[PRD_W-1] ? neg_z[MAG_W-1:0] : z_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      x_r <= dx * gain_s;
      z_r <= dz * gain_s;
    end
    if (cmd.sqr) begin
      xx_r <= Q_W'(mag_x) * Q_W'(mag_x);
      zz_r <= Q_W'(mag_z) * Q_W'(mag_z);
    end
  end

  // Integer square root, one result bit per cycle
  assign root_try = root_r + bit_r;
  assign len = root_r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rem_r  <= xx_r + zz_r + SCALE_Y_SQ;
      root_r <= '0;
      bit_r  <= ROOT_BIT0;
    end else if (cmd.root_step) begin
      if (rem_r >= root_try) begin
        rem_r  <= rem_r - root_try;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Restoring divider shared by the three components
  always_comb begin
    case (sel_r)
      COMP_X:  begin mag_sel = mag_x;   sign_sel = x_r[PRD_W-1]; end
      COMP_Z:  begin mag_sel = mag_z;   sign_sel = z_r[PRD_W-1]; end
      default: begin mag_sel = SCALE_Y; sign_sel = 1'b0;         end
    endcase
  end

  assign q_bit    = (drem_r >= dvs_r);
  assign quo_nxt  = {quo_r[QUO_W-2:0], q_bit};
  assign comp_mag = NRM_W'(quo_nxt);
  assign comp_val = sign_sel ? -comp_mag : comp_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= COMP_X;
    end else if (cmd.sum) begin
      sel_r <= COMP_X;
    end else if (cmd.div_step && dcnt_r == '0) begin
      unique case (sel_r)
        COMP_X:  sel_r <= COMP_Y;
        COMP_Y:  sel_r <= COMP_Z;
        default: sel_r <= COMP_X;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem_r <= {1'b0, mag_sel, {FRAC{1'b0}}} + DIV_W'(len >> 1);
      dvs_r  <= {1'b0, len, {FRAC{1'b0}}};
      quo_r  <= '0;
      dcnt_r <= 4'(FRAC);
    end else if (cmd.div_step) begin
      if (q_bit) begin
        drem_r <= drem_r - dvs_r;
      end
      dvs_r  <= dvs_r >> 1;
      quo_r  <= quo_nxt;
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == '0) begin
        case (sel_r)
          COMP_X:  nx_r <= comp_val;
          COMP_Y:  ny_r <= comp_val;
          default: nz_r <= comp_val;
        endcase
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ox_r <= nx_r;
      oy_r <= ny_r;
      oz_r <= nz_r;
    end
  end

  assign out_normal_x = ox_r;
  assign out_normal_y = oy_r;
  assign out_normal_z = oz_r;

  assign sts.root_last = bit_r[0];
  assign sts.div_last  = (dcnt_r == '0);
  assign sts.comp_last = (sel_r == COMP_Z);

endmodule

>>> src/hng_ctrl.sv
module hng_ctrl import hng_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int AW = $clog2(MAX_SIDE),
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int XW = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SIDE_CFG_W-1:0] side_cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [7:0]            in_height_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel_column,
  output logic [7:0]            out_pixel_row,
  output logic                  out_frame_end,
  output dp_cmd_t               cmd,
  input  dp_sts_t               sts,
  output logic [AW-1:0]         col,
  output logic [7:0]            sample
);

  localparam logic [XW-1:0] MAXS = XW'(MAX_SIDE);

  ctrl_state_t state_r, state_nxt;
  logic [AW-1:0] col_cnt_r, col_cnt_nxt, fl_cnt_r, fl_cnt_nxt, c_r, c_nxt;
  logic [SW-1:0] row_cnt_r, row_cnt_nxt;
  logic [7:0] sample_r, sample_nxt, orow_r, orow_nxt;
  logic flush_r, flush_nxt, lz_r, lz_nxt, rz_r, rz_nxt, dz_r, dz_nxt;
  logic emit_r, emit_nxt, last_r, last_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic out_last_r, out_last_nxt;

  logic [XW-1:0] side_x;
  logic [SW-1:0] side;

  // Clamp side length to 2..MAX_SIDE
  always_comb begin
    side_x = XW'(side_cfg);
    if (side_x < XW'(2)) begin
      side_x = XW'(2);
    end else if (side_x > MAXS) begin
      side_x = MAXS;
    end
  end
  assign side = SW'(side_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      fl_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      fl_cnt_r    <= fl_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    sample_r  <= sample_nxt;
    orow_r    <= orow_nxt;
    flush_r   <= flush_nxt;
    lz_r      <= lz_nxt;
    rz_r      <= rz_nxt;
    dz_r      <= dz_nxt;
    emit_r    <= emit_nxt;
    last_r    <= last_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    logic [AW-1:0] cc, fc, c;
    logic [SW-1:0] rc, c_inc;
    logic act;

    state_nxt    = state_r;
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    fl_cnt_nxt   = fl_cnt_r;
    c_nxt        = c_r;
    sample_nxt   = sample_r;
    orow_nxt     = orow_r;
    flush_nxt    = flush_r;
    lz_nxt       = lz_r;
    rz_nxt       = rz_r;
    dz_nxt       = dz_r;
    emit_nxt     = emit_r;
    last_nxt     = last_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready     = 1'b0;
    cmd          = '0;
    cc = col_cnt_r;
    fc = fl_cnt_r;
    rc = row_cnt_r;
    c  = '0;
    c_inc = '0;
    act = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Restart the frame when counters lie beyond a new side length
          if (SW'(cc) >= side || rc > side || SW'(fc) >= side) begin
            cc = '0;
            rc = '0;
            fc = '0;
          end
          if (in_command) begin
            c     = fc;
            c_inc = SW'(fc) + 1'b1;
            if (rc == side) begin
              act       = 1'b1;
              emit_nxt  = 1'b1;
              orow_nxt  = 8'(side - 1'b1);
              last_nxt  = (c_inc >= side);
              dz_nxt    = 1'b0;
              fc        = AW'(c_inc);
              if (c_inc >= side) begin
                cc = '0;
                rc = '0;
                fc = '0;
              end
            end
          end else begin
            c     = cc;
            c_inc = SW'(cc) + 1'b1;
            if (rc < side) begin
              act      = 1'b1;
              emit_nxt = (rc != '0);
              orow_nxt = 8'(rc - 1'b1);
              last_nxt = 1'b0;
              dz_nxt   = (rc == SW'(1));
              cc       = AW'(c_inc);
              if (c_inc >= side) begin
                cc = '0;
                rc = rc + 1'b1;
              end
            end
          end
          col_cnt_nxt = cc;
          row_cnt_nxt = rc;
          fl_cnt_nxt  = fc;
          c_nxt       = c;
          sample_nxt  = in_height_sample;
          flush_nxt   = in_command;
          lz_nxt      = (c == '0);
          rz_nxt      = (c_inc >= side);
          if (act) begin
            state_nxt = S_RD0;
          end
        end
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: begin
        cmd.rd1   = 1'b1;
        cmd.cap0  = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.cap1  = 1'b1;
        cmd.wr    = !flush_r;
        state_nxt = emit_r ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = sts.comp_last ? S_DONE : S_DIVI;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          out_col_nxt   = 8'(c_r);
          out_row_nxt   = orow_r;
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    cmd.flush  = flush_r;
    cmd.l_zero = lz_r;
    cmd.r_zero = rz_r;
    cmd.d_zero = dz_r;
  end

  assign col              = c_r;
  assign sample           = sample_r;
  assign out_valid        = out_valid_r;
  assign out_pixel_column = out_col_r;
  assign out_pixel_row    = out_row_r;
  assign out_frame_end    = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transaction");

  a_done_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished result not presented");

  a_root_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && sts.root_last) |=> (state_r == S_DIVI))
    else $error("division not started after square root");

  a_rd_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD0) |=> (state_r == S_RD1) ##1 (state_r == S_RD2))
    else $error("row buffer read sequence broken");

endmodule

>>> src/heightmap_normal_generator_top.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_command, in_height_sample
// out      out_valid / out_ready  out_normal_x/y/z, out_pixel_column, out_pixel_row,
//                                 out_frame_end
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One transaction at a time. An ignored sample or flush is dropped in idle; a first-row
// sample passes accept and the row buffer read/write states RD0, RD1 and RD2. One
// that yields a normal passes, with the output register free, accept, row buffer
// reads and squaring, the bit-serial square root, the shared divider for each of
// the three components and a load into the output register.
// The output register frees the controller while a result waits on out_ready.
// Reset (rst_n low, synchronous) clears counters and control; row buffers are
// not cleared.
module heightmap_normal_generator_top import hng_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [7:0]              in_height_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  output logic [7:0]              out_pixel_column,
  output logic [7:0]              out_pixel_row,
  output logic                    out_frame_end,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_SIDE);

  logic [SIDE_CFG_W-1:0] side_r;
  logic [GAIN_W-1:0]     gain_r;
  dp_cmd_t               cmd;
  dp_sts_t               sts;
  logic [AW-1:0]         col;
  logic [7:0]            sample;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIDE_LENGTH: side_r <= cfg_data[SIDE_CFG_W-1:0];
        CFG_HEIGHT_GAIN: gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  hng_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .side_cfg(side_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_height_sample(in_height_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_column(out_pixel_column), .out_pixel_row(out_pixel_row),
    .out_frame_end(out_frame_end),
    .cmd(cmd), .sts(sts), .col(col), .sample(sample)
  );

  hng_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .col(col), .sample(sample),
    .gain(gain_r),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z)
  );

endmodule
